// ===== rtl/core/xti_pkg.sv =====
`timescale 1ns / 1ps
// Package for the XML tag indenter: item structs, character codes, tag kinds
// and small helpers. It has no dependencies.
package xti_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_OPEN    = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_COMMENT = 2'd2,
    KIND_VERSION = 2'd3
  } tag_kind_e;

  localparam int unsigned MAX_LEVEL_DEF = 14;
  localparam int unsigned WIDTH_CAP     = 4;
  localparam int unsigned LEVEL_W       = 6;
  localparam int unsigned INDENT_W      = 3;

  localparam logic [INDENT_W-1:0]       INDENT_RST = INDENT_W'(WIDTH_CAP);
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN  = 6'sb100000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_RST  = -6'sd1;

  localparam logic        ACT_TEXT = 1'b0;
  localparam logic        ACT_END  = 1'b1;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_NL) || (ch == CH_TAB) || (ch == CH_SPACE);
  endfunction

  // One level down, holding at the lowest level.
  function automatic logic signed [LEVEL_W-1:0] level_dn(
      input logic signed [LEVEL_W-1:0] lvl);
    return (lvl != LEVEL_MIN) ? lvl - 6'sd1 : lvl;
  endfunction

endpackage

// ===== rtl/core/xml_tag_indenter_top.sv =====
`timescale 1ns / 1ps
// XML tag indenter top level, depends on xti_pkg: parses one text byte per
// transaction and emits the reformatted characters one per cycle while not stalled.
//
//  Channel  Direction  Handshake          Payload
//  in       input      in_valid/in_stall  xti_pkg::in_item_t  (action, text_byte)
//  out      output     out_valid/out_stall xti_pkg::out_item_t (out_char, run_last)
//  cfg      input      cfg_valid/cfg_ready indent width, 3 bits
//
// An input transaction is parsed in the cycle it is accepted; the characters it
// causes are then sent by the output sequencer, which stalls the input until the
// last of them is sent. An item without results does not stall the input.
// The single character path of the sequencer (newline, space run, tail bytes)
// sets the rate. Stall on the output freezes the sequencer; the output register
// lets the next input be taken while the last character still waits.
// Reset is asynchronous and active low; an end item also clears the parser
// state but keeps the indent width.
module xml_tag_indenter_top #(
  parameter int unsigned MAX_LEVEL = xti_pkg::MAX_LEVEL_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  xti_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output xti_pkg::out_item_t         out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [xti_pkg::INDENT_W-1:0] cfg_data_i
);
  import xti_pkg::*;

  localparam int unsigned LvlW = $clog2(MAX_LEVEL + 1);
  localparam int unsigned SpcW = $clog2(MAX_LEVEL * WIDTH_CAP + 1);
  localparam logic signed [LEVEL_W-1:0] LvlMax = LEVEL_W'(MAX_LEVEL);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // Parser state.
  logic [INDENT_W-1:0]       indent_q;
  logic [7:0]                prev_q, prev_d, pprev_q, pprev_d;
  logic                      close_open_q, close_open_d;
  logic                      after_close_q, after_close_d;
  tag_kind_e                 kind_q, kind_d;
  logic signed [LEVEL_W-1:0] level_q, level_d;
  logic                      first_q, first_d;
  logic                      skip_q, skip_d;
  logic                      lt_q, lt_d;

  // Output sequencer.
  logic                      state_q, state_d;
  logic                      nl_q, nl_d;
  logic [SpcW-1:0]           spc_q, spc_d;
  logic [1:0]                tail_q, tail_d;
  logic [7:0]                t0_q, t0_d, t1_q, t1_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                      in_acc, step;
  logic [7:0]                a;
  logic [INDENT_W-1:0]       w_eff;

  // Plan of one item's characters.
  logic                      p_nl;
  logic [SpcW-1:0]           p_spc;
  logic [1:0]                p_tail;
  logic [7:0]                p_t0, p_t1;

  logic                      nl_req, nl_comment, to_tag, ac;
  logic signed [LEVEL_W-1:0] nl_base, n2, lvl_up, lvl_t;

  assign in_stall_o  = (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign step        = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign a           = in_data_i.text_byte;
  assign w_eff       = (indent_q > INDENT_W'(WIDTH_CAP)) ? INDENT_W'(WIDTH_CAP) : indent_q;
  assign lvl_up      = (level_q < LvlMax) ? level_q + 6'sd1 : level_q;

  always_comb begin
    prev_d        = prev_q;
    pprev_d       = pprev_q;
    close_open_d  = close_open_q;
    after_close_d = after_close_q;
    kind_d        = kind_q;
    level_d       = level_q;
    first_d       = first_q;
    skip_d        = skip_q;
    lt_d          = lt_q;
    p_nl          = 1'b0;
    p_spc         = '0;
    p_tail        = 2'd0;
    p_t0          = CH_NL;
    p_t1          = CH_NL;
    nl_req        = 1'b0;
    nl_comment    = 1'b0;
    nl_base       = level_q;
    to_tag        = 1'b0;
    ac            = after_close_q;
    n2            = '0;
    lvl_t         = level_q;

    if (in_data_i.action == ACT_END) begin
      if (lt_q) begin
        p_tail = 2'd2;
        p_t0   = CH_LT;
        p_t1   = CH_NL;
      end else begin
        p_tail = 2'd1;
        p_t0   = CH_NL;
      end
      prev_d        = '0;
      pprev_d       = '0;
      close_open_d  = 1'b0;
      after_close_d = 1'b0;
      kind_d        = KIND_OPEN;
      level_d       = LEVEL_RST;
      first_d       = 1'b1;
      skip_d        = 1'b0;
      lt_d          = 1'b0;
    end else if (lt_q) begin
      lt_d   = 1'b0;
      p_tail = 2'd2;
      p_t0   = CH_LT;
      p_t1   = a;
      if (a == CH_SLASH) begin
        if (prev_q == CH_GT && (pprev_q == CH_SLASH || kind_q == KIND_CLOSE)) begin
          nl_req  = 1'b1;
          nl_base = level_q;
        end
        kind_d       = KIND_CLOSE;
        close_open_d = 1'b1;
      end else begin
        if (a == CH_BANG) begin
          kind_d     = KIND_COMMENT;
          nl_req     = 1'b1;
          nl_comment = 1'b1;
          nl_base    = lvl_up;
        end else if (a == CH_QUEST) begin
          kind_d = KIND_VERSION;
        end else begin
          kind_d  = KIND_OPEN;
          nl_req  = 1'b1;
          nl_base = lvl_up;
        end
        pprev_d = prev_q;
        prev_d  = CH_LT;
      end
    end else begin
      if (skip_q) begin
        if (!is_ws(a)) begin
          skip_d = 1'b0;
          to_tag = 1'b1;
        end
      end else if (prev_q == CH_QUEST && a == CH_GT) begin
        p_tail = 2'd2;
        p_t0   = CH_GT;
        p_t1   = CH_NL;
      end else begin
        ac            = after_close_q || (close_open_q && a == CH_GT);
        after_close_d = ac;
        if (ac && is_ws(a)) begin
          skip_d = skip_q;
        end else if (!ac && a == CH_NL) begin
          skip_d = 1'b1;
        end else if (prev_q == CH_GT && pprev_q == CH_SLASH && is_ws(a)) begin
          skip_d = 1'b1;
        end else begin
          to_tag = 1'b1;
        end
      end
      if (to_tag) begin
        if (a == CH_LT) begin
          after_close_d = 1'b0;
          lt_d          = 1'b1;
        end else begin
          lvl_t = level_q;
          if (close_open_q && a == CH_GT && kind_q != KIND_COMMENT) begin
            close_open_d = 1'b0;
            lvl_t        = level_dn(lvl_t);
          end
          if (a == CH_GT && prev_q == CH_SLASH) begin
            lvl_t = level_dn(lvl_t);
          end
          level_d = lvl_t;
          p_tail  = 2'd1;
          p_t0    = a;
          pprev_d = prev_q;
          prev_d  = a;
        end
      end
    end

    // New line with indentation: a negative level is raised to zero first.
    if (nl_req) begin
      n2      = nl_base[LEVEL_W-1] ? '0 : nl_base;
      p_nl    = !first_q;
      first_d = 1'b0;
      p_spc   = SpcW'(n2[LvlW-1:0]) * SpcW'(w_eff);
      level_d = nl_comment ? n2 - 6'sd1 : n2;
    end
  end

  always_comb begin
    state_d     = state_q;
    nl_d        = nl_q;
    spc_d       = spc_q;
    tail_d      = tail_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (in_acc) begin
      nl_d   = p_nl;
      spc_d  = p_spc;
      tail_d = p_tail;
      t0_d   = p_t0;
      t1_d   = p_t1;
      if (p_nl || p_spc != '0 || p_tail != 2'd0) begin
        state_d = ST_EMIT;
      end
    end else if (step) begin
      out_valid_d = 1'b1;
      if (nl_q) begin
        nl_d           = 1'b0;
        out_d.out_char = CH_NL;
        out_d.run_last = (spc_q == '0) && (tail_q == 2'd0);
      end else if (spc_q != '0) begin
        spc_d          = spc_q - SpcW'(1);
        out_d.out_char = CH_SPACE;
        out_d.run_last = (spc_q == SpcW'(1)) && (tail_q == 2'd0);
      end else begin
        tail_d         = tail_q - 2'd1;
        t0_d           = t1_q;
        out_d.out_char = t0_q;
        out_d.run_last = (tail_q == 2'd1);
      end
      if (out_d.run_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      indent_q      <= INDENT_RST;
      prev_q        <= '0;
      pprev_q       <= '0;
      close_open_q  <= 1'b0;
      after_close_q <= 1'b0;
      kind_q        <= KIND_OPEN;
      level_q       <= LEVEL_RST;
      first_q       <= 1'b1;
      skip_q        <= 1'b0;
      lt_q          <= 1'b0;
      state_q       <= ST_IDLE;
      nl_q          <= 1'b0;
      spc_q         <= '0;
      tail_q        <= 2'd0;
      t0_q          <= '0;
      t1_q          <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        indent_q <= cfg_data_i;
      end
      if (in_acc) begin
        prev_q        <= prev_d;
        pprev_q       <= pprev_d;
        close_open_q  <= close_open_d;
        after_close_q <= after_close_d;
        kind_q        <= kind_d;
        level_q       <= level_d;
        first_q       <= first_d;
        skip_q        <= skip_d;
        lt_q          <= lt_d;
      end
      state_q     <= state_d;
      nl_q        <= nl_d;
      spc_q       <= spc_d;
      tail_q      <= tail_d;
      t0_q        <= t0_d;
      t1_q        <= t1_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // The sequencer never sits busy with nothing left to send.
  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (nl_q || spc_q != '0 || tail_q != 2'd0))
    else $error("sequencer busy without pending characters");

  // A character that is not the last of its transaction is followed at once.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_last |=> out_valid_o)
    else $error("gap inside a character run");

  a_run_owns_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |-> state_q == ST_EMIT)
    else $error("run not finished but sequencer idle");

  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlMax)
    else $error("nesting level above its limit");

  a_lt_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lt_q && skip_q))
    else $error("pending tag open while skipping whitespace");

endmodule
